### hdl/dpe_pkg.sv
// shared types, op codes and sine coefficients for the dipole pair energy block
`timescale 1ns / 1ps
`default_nettype none
package dpe_pkg;

    localparam logic [1:0] OP_WR_ANGLE = 2'd0;
    localparam logic [1:0] OP_WR_TABLE = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int E_W    = 48;

    localparam logic signed [PROD_W-1:0] Q30_ONE = PROD_W'(64'sd1073741824);
    localparam logic signed [PROD_W-1:0] E_MAX   = PROD_W'(64'sh7FFF_FFFF_FFFF);
    localparam logic signed [PROD_W-1:0] E_MIN   = -PROD_W'(64'sh8000_0000_0000);

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         site_row;
        logic [3:0]         site_col;
        logic [3:0]         other_row;
        logic [3:0]         other_col;
        logic [15:0]        angle_value;
        logic signed [31:0] cube_factor;
        logic signed [31:0] fifth_factor;
    } req_item_t;

    typedef struct packed {
        logic signed [E_W-1:0] energy_total;
        logic signed [E_W-1:0] energy_u;
        logic signed [E_W-1:0] energy_v;
    } rsp_item_t;

    typedef struct packed {
        logic       start;
        logic [3:0] site_row;
        logic [3:0] site_col;
        logic [3:0] other_row;
        logic [3:0] other_col;
    } core_cmd_t;

    typedef struct packed {
        logic      busy;
        logic      done;
        rsp_item_t result;
    } core_stat_t;

    // odd polynomial for sin(pi/2 * x), Q1.30
    function automatic logic signed [MUL_W-1:0] sin_coef(input logic [2:0] k);
        logic signed [MUL_W-1:0] c;
        case (k)
            3'd0:    c = MUL_W'(64'sd1686629713);
            3'd1:    c = MUL_W'(64'sd693598668);
            3'd2:    c = MUL_W'(64'sd85569306);
            3'd3:    c = MUL_W'(64'sd5026995);
            3'd4:    c = MUL_W'(64'sd172272);
            3'd5:    c = MUL_W'(64'sd3864);
            default: c = '0;
        endcase
        return c;
    endfunction

    // round half up, then floor shift
    function automatic logic signed [PROD_W-1:0] rnd_shr(
        input logic signed [PROD_W-1:0] v,
        input int                       s
    );
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [E_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        if (v > E_MAX)
        begin
            r = E_MAX;
        end
        else if (v < E_MIN)
        begin
            r = E_MIN;
        end
        else
        begin
            r = v;
        end
        return r[E_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hdl/dpe_mem.sv
// angle store and the two distance factor tables, registered reads
`timescale 1ns / 1ps
`default_nettype none
module dpe_mem #(
    parameter int AW    = 8,
    parameter int DEPTH = 256,
    parameter int AB    = 16
) (
    input  wire logic                 clk,
    input  wire logic                 ang_we,
    input  wire logic                 tab_we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [AB-1:0]        wangle,
    input  wire logic signed [31:0]   wcube,
    input  wire logic signed [31:0]   wfifth,
    input  wire logic [AW-1:0]        ang_raddr,
    input  wire logic [AW-1:0]        tab_raddr,
    output logic [AB-1:0]             ang_rdata,
    output logic signed [31:0]        cube_rdata,
    output logic signed [31:0]        fifth_rdata
);

    logic [AB-1:0]      angle_mem [DEPTH];
    logic signed [31:0] cube_mem  [DEPTH];
    logic signed [31:0] fifth_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ang_we)
        begin
            angle_mem[waddr] <= wangle;
        end
        ang_rdata <= angle_mem[ang_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            cube_mem[waddr]  <= wcube;
            fifth_mem[waddr] <= wfifth;
        end
        cube_rdata  <= cube_mem[tab_raddr];
        fifth_rdata <= fifth_mem[tab_raddr];
    end

endmodule
`default_nettype wire

### hdl/dpe_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module dpe_mul
    import dpe_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0]      prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

### hdl/dpe_core.sv
// query sequencer: operand fetch, four quarter-sine evaluations, energy terms
`timescale 1ns / 1ps
`default_nettype none
module dpe_core
    import dpe_pkg::*;
#(
    parameter int SIDE = 16,
    parameter int AB   = 16,
    parameter int AW   = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire core_cmd_t           cmd,
    output core_stat_t               stat,
    output logic [AW-1:0]            ang_raddr,
    output logic [AW-1:0]            tab_raddr,
    input  wire logic [AB-1:0]       ang_rdata,
    input  wire logic signed [31:0]  cube_rdata,
    input  wire logic signed [31:0]  fifth_rdata
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_RD0  = 3'd1;
    localparam logic [2:0] PH_RD1  = 3'd2;
    localparam logic [2:0] PH_RD2  = 3'd3;
    localparam logic [2:0] PH_EVAL = 3'd4;
    localparam logic [2:0] PH_POST = 3'd5;

    localparam logic [2:0] SB_SQ    = 3'd0;
    localparam logic [2:0] SB_FIRST = 3'd1;
    localparam logic [2:0] SB_LAST  = 3'd6;
    localparam logic [2:0] SB_CAP   = 3'd7;

    localparam logic [3:0] P_NM0  = 4'd0;
    localparam logic [3:0] P_NM1  = 4'd1;
    localparam logic [3:0] P_DOT  = 4'd2;
    localparam logic [3:0] P_DN1  = 4'd3;
    localparam logic [3:0] P_PRN  = 4'd4;
    localparam logic [3:0] P_DM1  = 4'd5;
    localparam logic [3:0] P_PRM  = 4'd6;
    localparam logic [3:0] P_U    = 4'd7;
    localparam logic [3:0] P_PP   = 4'd8;
    localparam logic [3:0] P_VMUL = 4'd9;
    localparam logic [3:0] P_V    = 4'd10;
    localparam logic [3:0] P_DONE = 4'd11;

    logic [2:0] ph_reg, ph_next;
    logic [2:0] sub_reg, sub_next;
    logic [1:0] ev_reg, ev_next;
    logic [3:0] pst_reg, pst_next;

    logic [AW-1:0] n_addr_reg, m_addr_reg, ti_reg;
    logic signed [4:0] d0_reg, d1_reg;
    logic [AB-1:0] an_reg, am_reg;
    logic signed [31:0] cube_reg, fifth_reg;
    logic [30:0] res_reg [4];
    logic signed [MUL_W-1:0] x2_reg, dot_reg, prn_reg, prm_reg, pp_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [E_W-1:0] u_reg, v_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_q30, sum_pp;
    logic signed [4:0] d0_new, d1_new;
    logic [3:0] a0_new, a1_new;
    logic [29:0] xn, xm, xbase;
    logic [30:0] x_cur;
    logic signed [MUL_W-1:0] x_op, horner;
    logic signed [MUL_W-1:0] pn0, pn1, pm0, pm1;

    dpe_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    assign d0_new = 5'({1'b0, cmd.other_row} - {1'b0, cmd.site_row});
    assign d1_new = 5'({1'b0, cmd.other_col} - {1'b0, cmd.site_col});
    assign a0_new = (d0_new < 0) ? 4'(-d0_new) : 4'(d0_new);
    assign a1_new = (d1_new < 0) ? 4'(-d1_new) : 4'(d1_new);

    // remainder of the turn scaled to Q1.30
    assign xn    = {an_reg[AB-3:0], (32 - AB)'(0)};
    assign xm    = {am_reg[AB-3:0], (32 - AB)'(0)};
    assign xbase = ev_reg[1] ? xm : xn;
    assign x_cur = ev_reg[0] ? (31'h4000_0000 - 31'(xbase)) : 31'(xbase);
    assign x_op  = MUL_W'(x_cur);

    assign prod_q30 = prod >>> 30;
    assign horner   = sin_coef(3'(SB_LAST) - sub_reg) - MUL_W'(prod_q30);
    assign sum_pp   = acc_reg + prod;

    // quadrant folding: (C,S), (-S,C), (-C,-S), (S,-C)
    function automatic logic signed [2*MUL_W-1:0] fold(
        input logic [1:0]  q,
        input logic [30:0] s,
        input logic [30:0] c
    );
        logic signed [MUL_W-1:0] sv, cv, r0, r1;
        sv = MUL_W'(s);
        cv = MUL_W'(c);
        case (q)
            2'd0:    begin r0 = cv;  r1 = sv;  end
            2'd1:    begin r0 = -sv; r1 = cv;  end
            2'd2:    begin r0 = -cv; r1 = -sv; end
            default: begin r0 = sv;  r1 = -cv; end
        endcase
        return {r0, r1};
    endfunction

    assign {pn0, pn1} = fold(an_reg[AB-1:AB-2], res_reg[0], res_reg[1]);
    assign {pm0, pm1} = fold(am_reg[AB-1:AB-2], res_reg[2], res_reg[3]);

    assign ang_raddr = (ph_reg == PH_RD0) ? n_addr_reg : m_addr_reg;
    assign tab_raddr = ti_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ph_reg)
            PH_EVAL:
            begin
                case (sub_reg)
                    SB_SQ:
                    begin
                        mul_a = x_op;
                        mul_b = x_op;
                    end
                    SB_FIRST:
                    begin
                        mul_a = sin_coef(3'd5);
                        mul_b = MUL_W'(prod_q30);
                    end
                    SB_LAST:
                    begin
                        mul_a = horner;
                        mul_b = x_op;
                    end
                    SB_CAP:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                    default:
                    begin
                        mul_a = horner;
                        mul_b = x2_reg;
                    end
                endcase
            end
            PH_POST:
            begin
                case (pst_reg)
                    P_NM0:  begin mul_a = pn0; mul_b = pm0; end
                    P_NM1:  begin mul_a = pn1; mul_b = pm1; end
                    P_DOT:  begin mul_a = MUL_W'(d0_reg); mul_b = pn0; end
                    P_DN1:  begin mul_a = MUL_W'(d1_reg); mul_b = pn1; end
                    P_PRN:  begin mul_a = MUL_W'(d0_reg); mul_b = pm0; end
                    P_DM1:  begin mul_a = MUL_W'(d1_reg); mul_b = pm1; end
                    P_PRM:  begin mul_a = MUL_W'(cube_reg); mul_b = dot_reg; end
                    P_U:    begin mul_a = prn_reg; mul_b = prm_reg; end
                    P_VMUL: begin mul_a = MUL_W'(fifth_reg); mul_b = pp_reg; end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        ph_next  = ph_reg;
        sub_next = sub_reg;
        ev_next  = ev_reg;
        pst_next = pst_reg;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (cmd.start)
                begin
                    ph_next = PH_RD0;
                end
            end
            PH_RD0: ph_next = PH_RD1;
            PH_RD1: ph_next = PH_RD2;
            PH_RD2:
            begin
                ph_next  = PH_EVAL;
                sub_next = SB_SQ;
                ev_next  = 2'd0;
            end
            PH_EVAL:
            begin
                sub_next = sub_reg + 3'd1;
                if (sub_reg == SB_CAP)
                begin
                    ev_next = ev_reg + 2'd1;
                    if (ev_reg == 2'd3)
                    begin
                        ph_next  = PH_POST;
                        pst_next = P_NM0;
                    end
                end
            end
            PH_POST:
            begin
                pst_next = pst_reg + 4'd1;
                if (pst_reg == P_DONE)
                begin
                    ph_next = PH_IDLE;
                end
            end
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_IDLE;
            sub_reg <= '0;
            ev_reg  <= '0;
            pst_reg <= '0;
        end
        else
        begin
            ph_reg  <= ph_next;
            sub_reg <= sub_next;
            ev_reg  <= ev_next;
            pst_reg <= pst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_IDLE && cmd.start)
        begin
            n_addr_reg <= AW'(int'(cmd.site_row) * SIDE + int'(cmd.site_col));
            m_addr_reg <= AW'(int'(cmd.other_row) * SIDE + int'(cmd.other_col));
            ti_reg     <= AW'(int'(a0_new) * SIDE + int'(a1_new));
            d0_reg     <= d0_new;
            d1_reg     <= d1_new;
        end
        if (ph_reg == PH_RD1)
        begin
            an_reg    <= ang_rdata;
            cube_reg  <= cube_rdata;
            fifth_reg <= fifth_rdata;
        end
        if (ph_reg == PH_RD2)
        begin
            am_reg <= ang_rdata;
        end
        if (ph_reg == PH_EVAL && sub_reg == SB_FIRST)
        begin
            x2_reg <= MUL_W'(prod_q30);
        end
        if (ph_reg == PH_EVAL && sub_reg == SB_CAP)
        begin
            // clamp to [0, 1.0]
            if (prod_q30 > Q30_ONE)
            begin
                res_reg[ev_reg] <= 31'h4000_0000;
            end
            else if (prod_q30 < 0)
            begin
                res_reg[ev_reg] <= '0;
            end
            else
            begin
                res_reg[ev_reg] <= 31'(prod_q30);
            end
        end
        if (ph_reg == PH_POST)
        begin
            case (pst_reg) inside
                P_NM1, P_DN1, P_DM1: acc_reg <= prod;
                P_DOT:  dot_reg <= MUL_W'(rnd_shr(sum_pp, 30));
                P_PRN:  prn_reg <= MUL_W'(rnd_shr(sum_pp, 6));
                P_PRM:  prm_reg <= MUL_W'(rnd_shr(sum_pp, 6));
                P_U:    u_reg   <= sat48(rnd_shr(prod, 30));
                P_PP:   pp_reg  <= MUL_W'(rnd_shr(prod, 28));
                P_V:    v_reg   <= sat48(rnd_shr(prod, 20));
                default: ;
            endcase
        end
    end

    assign stat.busy = (ph_reg != PH_IDLE);
    assign stat.done = (ph_reg == PH_POST) && (pst_reg == P_DONE);
    assign stat.result.energy_total = sat48(PROD_W'(u_reg) + PROD_W'(v_reg));
    assign stat.result.energy_u     = u_reg;
    assign stat.result.energy_v     = v_reg;

endmodule
`default_nettype wire

### hdl/dipole_pair_energy.sv
// top level: request decode, table and angle writes, result register
`timescale 1ns / 1ps
`default_nettype none
// Dipole pair energy on a SIDE x SIDE lattice. Writes (angle or table entry) and
// items that carry no query skip the core and go to the result register.
// A pair query runs memory fetch, four quarter-sine evaluations (cos and sin
// of both dipoles, 7 Horner multiplies each), the dot product, the projections
// and the two energy terms, then loads the result register once the output is
// free. Every multiply runs on one shared 34x34 signed multiplier. The block
// takes one item at a time; req_ready is high only while nothing is in
// progress, and a new item is taken while the previous result still waits in
// the result register.
// Angles and table entries have no reset value and must be written before use.
module dipole_pair_energy
    import dpe_pkg::*;
#(
    parameter int SIDE       = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_item_t  req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_item_t       rsp
);

    localparam int SITES = SIDE * SIDE;
    localparam int AW    = $clog2(SITES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_item_t  rsp_reg;
    rsp_item_t  res_reg;

    logic       accept, n_ok, m_ok, load_out;
    logic       ang_we, tab_we;
    logic [AW-1:0] waddr, ang_raddr, tab_raddr;
    logic [ANGLE_BITS-1:0] ang_rdata;
    logic signed [31:0] cube_rdata, fifth_rdata;
    core_cmd_t  cmd;
    core_stat_t stat;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign n_ok      = (int'(req.site_row) < SIDE) && (int'(req.site_col) < SIDE);
    assign m_ok      = (int'(req.other_row) < SIDE) && (int'(req.other_col) < SIDE);
    assign ang_we    = accept && n_ok && (req.op == OP_WR_ANGLE);
    assign tab_we    = accept && n_ok && (req.op == OP_WR_TABLE);
    assign waddr     = AW'(int'(req.site_row) * SIDE + int'(req.site_col));

    assign cmd.start     = accept && n_ok && m_ok && (req.op == OP_QUERY);
    assign cmd.site_row  = req.site_row;
    assign cmd.site_col  = req.site_col;
    assign cmd.other_row = req.other_row;
    assign cmd.other_col = req.other_col;

    dpe_mem #(
        .AW    (AW),
        .DEPTH (SITES),
        .AB    (ANGLE_BITS)
    ) u_mem (
        .clk         (clk),
        .ang_we      (ang_we),
        .tab_we      (tab_we),
        .waddr       (waddr),
        .wangle      (ANGLE_BITS'(req.angle_value)),
        .wcube       (req.cube_factor),
        .wfifth      (req.fifth_factor),
        .ang_raddr   (ang_raddr),
        .tab_raddr   (tab_raddr),
        .ang_rdata   (ang_rdata),
        .cube_rdata  (cube_rdata),
        .fifth_rdata (fifth_rdata)
    );

    dpe_core #(
        .SIDE (SIDE),
        .AB   (ANGLE_BITS),
        .AW   (AW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .ang_raddr   (ang_raddr),
        .tab_raddr   (tab_raddr),
        .ang_rdata   (ang_rdata),
        .cube_rdata  (cube_rdata),
        .fifth_rdata (fifth_rdata)
    );

    assign load_out = (state_reg == ST_HOLD) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cmd.start ? ST_RUN : ST_HOLD;
                end
            end
            ST_RUN:
            begin
                if (stat.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // writes, unknown ops and out-of-range queries give a zero item
        if (accept)
        begin
            res_reg <= '0;
        end
        else if (stat.done)
        begin
            res_reg <= stat.result;
        end
        if (load_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == ST_RUN))
        else $error("core finished outside a query");

    a_ready_idle_core: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !stat.busy)
        else $error("ready while the core is busy");

    a_done_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (state_reg == ST_HOLD))
        else $error("query result not held");

    a_start_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> stat.busy)
        else $error("core did not start");

endmodule
`default_nettype wire
